### hw/rtl/tkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared widths, constants, stage payload types and the tanh table for the
// tanh-knee soft clipper.
// ----------------------------------------------------------------------------
package tkc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TABLE_DEPTH  = 128;

  // stream word widths, fields padded to whole bytes
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W       = 15;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // magnitude of the most negative sample needs one extra bit
  localparam int MAG_W  = SAMPLE_WIDTH + 1;
  // 3 * excess over the knee, never narrower than 17 so the saturation test exists
  localparam int T_W    = (MAG_W + 2 > 17) ? MAG_W + 2 : 17;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int POS_W  = FRAC_W + IDX_W;
  localparam int ROM_N  = 2 ** IDX_W;
  localparam int ROM_W  = 14;
  localparam int KNEE_W = 13;
  // shoulder times interpolated tanh, plus rounding
  localparam int PROD_W = 26;

  localparam int KNEE_Q13     = 5461;
  localparam int SHOULDER_Q13 = 2731;
  localparam int ONE_Q13      = 8192;
  localparam int ROUND_FRAC   = 32768;
  localparam int ROUND_Q13    = 4096;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic [ROM_N-1:0][ROM_W-1:0] tkc_rom_t;

  // payload leaving the front end: table position plus what the output needs
  typedef struct packed {
    logic              neg;
    logic              above;
    logic              sat;
    logic [KNEE_W-1:0] mag_lo;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
  } tkc_dist_t;

  // payload leaving the interpolator
  typedef struct packed {
    logic              neg;
    logic              above;
    logic [KNEE_W-1:0] mag_lo;
    logic [ROM_W-1:0]  interp;
  } tkc_tanh_t;

  // floor(n / d) found bit by bit with compares, for table building only
  function automatic logic [63:0] quot_search(logic [63:0] n, logic [63:0] d);
    logic [63:0]  q;
    logic [63:0]  cand;
    logic [127:0] prod;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      prod = {64'd0, cand} * {64'd0, d};
      if (prod <= {64'd0, n}) q = cand;
    end
    return q;
  endfunction

  // tanh(8*i/TABLE_DEPTH) in Q.13; entries past the table hold 1.0
  function automatic tkc_rom_t build_tanh_rom();
    tkc_rom_t    rom;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] base;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    term = 64'd1 << 40;
    sum  = term;
    // e^(-16/TABLE_DEPTH) by Taylor series in Q40
    for (int k = 1; k <= 30; k++) begin
      term = quot_search(term * 64'd16, 64'(TABLE_DEPTH) * 64'(k));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    base = (sum + (64'd1 << 9)) >> 10;
    e    = ONE_Q30;
    for (int i = 0; i < ROM_N; i++) begin
      if (i < TABLE_DEPTH) begin
        num    = ONE_Q30 - e;
        den    = ONE_Q30 + e;
        q      = quot_search(num * 64'd16384 + den, den << 1);
        rom[i] = q[ROM_W-1:0];
        e      = (e * base + (64'd1 << 29)) >> 30;
      end else begin
        rom[i] = ROM_W'(ONE_Q13);
      end
    end
    return rom;
  endfunction

  localparam tkc_rom_t TANH_ROM = build_tanh_rom();

endpackage

### hw/rtl/tanh_knee_soft_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_knee_soft_clipper
// Soft clipper for Q2.13 audio: linear up to the knee, tanh shoulder above.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+------------------------------
//  s_axis  | in  | s_axis_tvalid / tready  | sample_in, signed Q2.13
//  m_axis  | out | m_axis_tvalid / tready  | sample_out, signed Q1.13
//
//  One sample per cycle while m_axis_tready stays high; each sample passes
//  through the pipeline (magnitude, distance, table position, lookup,
//  interpolation, output scaling), one register stage each.
//  Reset (rst, synchronous) clears the stage valid bits only; the tanh table
//  is constant logic and needs no fill.
//  A stall on m_axis_tready holds the output word; earlier stages keep
//  filling until each holds a word, so bubbles collapse and nothing is lost.
// ----------------------------------------------------------------------------
module tanh_knee_soft_clipper import tkc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [14:0] sample_out, [15] zero
);

  // front end to interpolator
  logic      dist_valid, dist_ready;
  tkc_dist_t dist_data;
  // interpolator to output stage
  logic      tanh_valid, tanh_ready;
  tkc_tanh_t tanh_data;

  logic [OUT_W-1:0] sample_out;

  // magnitude, excess over the knee, table index and fraction
  tkc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_data  (dist_data)
  );

  // tanh table read and linear interpolation, saturating past the table
  tkc_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_data   (dist_data),
    .out_valid (tanh_valid),
    .out_ready (tanh_ready),
    .out_data  (tanh_data)
  );

  // shoulder scaling, knee offset, sign; also the output register
  tkc_shape u_shape (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tanh_valid),
    .in_ready   (tanh_ready),
    .in_data    (tanh_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .sample_out (sample_out)
  );

  // pad the field to a whole byte
  assign m_axis_tdata = {(OUT_TDATA_W - OUT_W)'(0), sample_out};

endmodule

### hw/rtl/tkc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_front
// Three stages: magnitude and sign, distance past the knee, table position.
// ----------------------------------------------------------------------------
module tkc_front import tkc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tkc_dist_t               out_data
);

  logic             a_valid, b_valid, c_valid;
  logic             a_en, b_en, c_en;
  logic             a_neg;
  logic [MAG_W-1:0] a_mag;
  logic             b_neg, b_above;
  logic [KNEE_W-1:0] b_mag_lo;
  logic [T_W-1:0]   b_t;
  tkc_dist_t        c_data;

  logic [MAG_W-1:0] sx;
  logic [MAG_W-1:0] a_mag_next;
  logic [T_W-1:0]   excess;
  logic [T_W-1:0]   b_t_next;
  logic [POS_W-1:0] pos;

  assign c_en     = !c_valid || out_ready;
  assign b_en     = !b_valid || c_en;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  assign sx         = {sample[SAMPLE_WIDTH-1], sample};
  assign a_mag_next = sample[SAMPLE_WIDTH-1] ? (MAG_W'(0) - sx) : sx;

  assign excess   = T_W'(a_mag) - T_W'(KNEE_Q13);
  assign b_t_next = excess + (excess << 1);

  assign pos = POS_W'(b_t[FRAC_W-1:0]) * POS_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= in_valid;
      if (b_en) b_valid <= a_valid;
      if (c_en) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_neg <= sample[SAMPLE_WIDTH-1];
      a_mag <= a_mag_next;
    end
    if (b_en) begin
      b_neg    <= a_neg;
      b_above  <= a_mag > MAG_W'(KNEE_Q13);
      b_mag_lo <= a_mag[KNEE_W-1:0];
      b_t      <= b_t_next;
    end
    if (c_en) begin
      c_data.neg    <= b_neg;
      c_data.above  <= b_above;
      c_data.sat    <= |b_t[T_W-1:FRAC_W];
      c_data.mag_lo <= b_mag_lo;
      c_data.idx    <= pos[FRAC_W +: IDX_W];
      c_data.frac   <= pos[FRAC_W-1:0];
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

### hw/rtl/tkc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_interp
// Two stages: table lookup of both segment ends, then linear interpolation.
// ----------------------------------------------------------------------------
module tkc_interp import tkc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tkc_dist_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tkc_tanh_t out_data
);

  logic              d_valid, e_valid;
  logic              d_en, e_en;
  logic              d_neg, d_above, d_sat;
  logic [KNEE_W-1:0] d_mag_lo;
  logic [ROM_W-1:0]  d_y0, d_diff;
  logic [FRAC_W-1:0] d_frac;
  tkc_tanh_t         e_data;

  logic [IDX_W-1:0]  idx_up;
  logic [ROM_W-1:0]  y0, y1;
  logic [ROM_W+FRAC_W:0] prod;
  logic [ROM_W-1:0]  step;

  assign e_en     = !e_valid || out_ready;
  assign d_en     = !d_valid || e_en;
  assign in_ready = d_en;

  // the point after the last entry is 1.0
  assign idx_up = in_data.idx + IDX_W'(1);
  assign y0     = TANH_ROM[in_data.idx];
  assign y1     = (in_data.idx == IDX_W'(TABLE_DEPTH - 1)) ? ROM_W'(ONE_Q13)
                                                            : TANH_ROM[idx_up];

  assign prod = (ROM_W+FRAC_W+1)'(d_diff) * (ROM_W+FRAC_W+1)'(d_frac)
              + (ROM_W+FRAC_W+1)'(ROUND_FRAC);
  assign step = prod[FRAC_W +: ROM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (d_en) d_valid <= in_valid;
      if (e_en) e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_neg    <= in_data.neg;
      d_above  <= in_data.above;
      d_sat    <= in_data.sat;
      d_mag_lo <= in_data.mag_lo;
      d_frac   <= in_data.frac;
      d_y0     <= y0;
      d_diff   <= y1 - y0;
    end
    if (e_en) begin
      e_data.neg    <= d_neg;
      e_data.above  <= d_above;
      e_data.mag_lo <= d_mag_lo;
      e_data.interp <= d_sat ? ROM_W'(ONE_Q13) : d_y0 + step;
    end
  end

  assign out_valid = e_valid;
  assign out_data  = e_data;

endmodule

### hw/rtl/tkc_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_shape
// Output stage: scale by the shoulder, add the knee, restore the sign.
// ----------------------------------------------------------------------------
module tkc_shape import tkc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tkc_tanh_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] sample_out
);

  logic              f_en;
  logic [PROD_W-1:0] scaled;
  logic [ROM_W-1:0]  mag_knee;
  logic [ROM_W-1:0]  mag_sel;
  logic [OUT_W-1:0]  signed_next;

  assign f_en     = !out_valid || out_ready;
  assign in_ready = f_en;

  assign scaled   = PROD_W'(SHOULDER_Q13) * PROD_W'(in_data.interp) + PROD_W'(ROUND_Q13);
  assign mag_knee = ROM_W'(KNEE_Q13) + ROM_W'(scaled[PROD_W-1:13]);
  assign mag_sel  = in_data.above ? mag_knee : ROM_W'(in_data.mag_lo);
  assign signed_next = in_data.neg ? (OUT_W'(0) - OUT_W'(mag_sel)) : OUT_W'(mag_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (f_en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) sample_out <= signed_next;
  end

endmodule

### hw/rtl/tkc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_checker
// Port-level checks of the soft clipper, bound to the top level.
// ----------------------------------------------------------------------------
module tkc_checker import tkc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // magnitude never above full scale, pad bit zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0
      && $signed(m_axis_tdata[OUT_W-1:0]) <= $signed(15'sd8192)
      && $signed(m_axis_tdata[OUT_W-1:0]) >= $signed(-15'sd8192))
    else $error("output sample out of range");

  // with no back pressure an accepted word passes every stage and shows up at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(s_acc, 6) && !$past(rst, 6) && !$past(rst, 5) && !$past(rst, 4)
      && !$past(rst, 3) && !$past(rst, 2) && !$past(rst, 1)
      && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
      && $past(m_axis_tready, 3) && $past(m_axis_tready, 4)
      && $past(m_axis_tready, 5)
    |-> m_axis_tvalid)
    else $error("accepted word did not reach the output in time");

endmodule

bind tanh_knee_soft_clipper tkc_checker u_tkc_checker (.*);

### tb/tb_tanh_knee_soft_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tanh_knee_soft_clipper
// Self-checking bench for the tanh-knee soft clipper. A directed table covers
// the knee, the last table segment, saturation and the most negative sample.
// Random samples follow, weighted toward the shoulder. Both stream sides idle
// at random. Every output word is checked against a typed-in value or a local predictor.
// ----------------------------------------------------------------------------
module tb_tanh_knee_soft_clipper;
  import tkc_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_SAMPLES  = 1030;
  localparam int N_DIRECTED      = 21;

  // one stimulus row; known = 1 means sample_out is typed in, else predicted
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    known;
    logic [OUT_W-1:0]        sample_out;
  } stim_row_t;

  // one pending output word, with the sample that caused it for messages
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [OUT_W-1:0]        sample_out;
  } clip_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [15:0] sample_in
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [14:0] sample_out, [15] pad

  longint unsigned tanh_pts [TABLE_DEPTH];
  clip_word_t      expected_out [$];
  int              fail_count = 0;
  int              idle_cycles = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'sd0,          1'b1, 15'd0},
    '{16'sd1,          1'b1, 15'd1},
    '{-16'sd1,         1'b1, 15'h7FFF},
    // knee: at or below passes unchanged
    '{16'sd5461,       1'b1, 15'd5461},
    '{-16'sd5461,      1'b1, 15'(-5461)},
    '{16'sd5462,       1'b0, 15'd0},
    '{-16'sd5462,      1'b0, 15'd0},
    '{16'sd8192,       1'b0, 15'd0},
    '{-16'sd8192,      1'b0, 15'd0},
    '{16'sd16384,      1'b0, 15'd0},
    '{-16'sd16384,     1'b0, 15'd0},
    // second to last and last table segment (upper point is 1.0)
    '{16'sd27135,      1'b0, 15'd0},
    '{16'sd27136,      1'b0, 15'd0},
    '{16'sd27306,      1'b0, 15'd0},
    '{-16'sd27306,     1'b0, 15'd0},
    // first distance past 8: saturates to full scale
    '{16'sd27307,      1'b1, 15'd8192},
    '{-16'sd27307,     1'b1, 15'(-8192)},
    '{16'sd32767,      1'b1, 15'd8192},
    // most negative sample, magnitude formed in 17 bits
    '{16'h8000,        1'b1, 15'(-8192)},
    '{16'h5555,        1'b0, 15'd0},
    '{16'hAAAA,        1'b0, 15'd0}
  };

  tanh_knee_soft_clipper DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the clipped output of one Q2.13 sample.
  function automatic logic [OUT_W-1:0] clip_sample(logic [SAMPLE_WIDTH-1:0] x);
    logic            neg;
    longint unsigned mag;
    longint unsigned span;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned th;
    longint unsigned mag_out;
    neg = x[SAMPLE_WIDTH-1];
    mag = neg ? ((64'd1 << SAMPLE_WIDTH) - 64'(x)) : 64'(x);
    if (mag <= KNEE_Q13) begin
      mag_out = mag;
    end else begin
      span = 3 * (mag - KNEE_Q13);
      pos  = span * TABLE_DEPTH;
      idx  = pos >> FRAC_W;
      frac = pos & 64'hFFFF;
      if (idx >= TABLE_DEPTH) begin
        th = ONE_Q13;
      end else begin
        lo = tanh_pts[idx];
        // past the last entry the curve sits at 1.0
        hi = (idx + 1 < TABLE_DEPTH) ? tanh_pts[idx + 1] : ONE_Q13;
        th = lo + (((hi - lo) * frac + ROUND_FRAC) >> FRAC_W);
      end
      mag_out = KNEE_Q13 + ((SHOULDER_Q13 * th + ROUND_Q13) >> 13);
    end
    return neg ? OUT_W'(-mag_out) : OUT_W'(mag_out);
  endfunction

  // Draw a random sample, weighted toward the knee and the shoulder.
  function automatic logic [SAMPLE_WIDTH-1:0] draw_sample();
    int mag;
    case ($urandom_range(0, 4))
      0: return SAMPLE_WIDTH'($urandom);
      1: mag = $urandom_range(0, KNEE_Q13);
      2: mag = $urandom_range(KNEE_Q13 + 1, 27307);
      3: mag = $urandom_range(KNEE_Q13 - 4, KNEE_Q13 + 4);
      default: begin
        if ($urandom_range(0, 7) == 0) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        mag = $urandom_range(27308, 32767);
      end
    endcase
    return $urandom_range(0, 1) ? SAMPLE_WIDTH'(-mag) : SAMPLE_WIDTH'(mag);
  endfunction

  // Check each output word against the oldest pending prediction.
  always @(posedge clk) begin
    clip_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want.sample_out) begin
          $error("sample_out for sample_in %h: expected %h, actual %h",
                 want.sample, want.sample_out, m_axis_tdata[OUT_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
          $error("tdata pad for sample_in %h: expected 0, actual %b",
                 want.sample, m_axis_tdata[OUT_TDATA_W-1:OUT_W]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run once nothing moves for too long.
  initial begin
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Output side: a random stall before each word, except in stall-free stretches.
  initial begin
    int words;
    int stall;
    words = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = ((words / 90) % 3 == 1) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      words++;
    end
  end

  // Input side: build the curve, reset, walk the table, then random samples.
  initial begin
    longint unsigned term;
    longint unsigned sum;
    longint unsigned base;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    stim_row_t       row;
    clip_word_t      word;
    int              gap;

    // e^(-16/TABLE_DEPTH) by Taylor series in Q40, then rounded to Q30
    term = 64'd1 << 40;
    sum  = term;
    for (int k = 1; k <= 30; k++) begin
      term = (term * 16) / (64'(TABLE_DEPTH) * 64'(k));
      if (k % 2) sum -= term;
      else sum += term;
    end
    base = (sum + (64'd1 << 9)) >> 10;
    // tanh(x) = (1 - e^-2x) / (1 + e^-2x), rounded to nearest Q.13
    e = ONE_Q30;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      num         = ONE_Q30 - e;
      den         = ONE_Q30 + e;
      tanh_pts[i] = (num * (2 * ONE_Q13) + den) / (2 * den);
      e           = (e * base + (64'd1 << 29)) >> 30;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_DIRECTED + RANDOM_SAMPLES; n++) begin
      if (n < N_DIRECTED) begin
        row = directed_rows[n];
      end else begin
        row.sample = draw_sample();
        row.known  = 1'b0;
      end
      word.sample     = row.sample;
      word.sample_out = row.known ? row.sample_out : clip_sample(row.sample);

      // idle at random before the word, except in back-to-back stretches
      gap = ((n / 80) % 3 == 2) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= IN_TDATA_W'(row.sample);
      do @(posedge clk); while (!s_axis_tready);
      expected_out.push_back(word);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give stray words time to show up
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
